[src/tkee_pkg.sv]
`default_nettype none

package tkee_pkg;

    // One input beat: a key event.
    typedef struct packed {
        logic [6:0] key_index;
        logic       pressed;
    } tkee_in_t;

    // One result beat: a byte of the sequence or a local action.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [3:0] local_action;
        logic       last_of_run;
    } tkee_out_t;

    // Key numbering.
    localparam int unsigned NAV_KEYS     = 22;
    localparam int unsigned ACTION_KEYS  = 8;
    localparam int unsigned KEY_MOD_BASE = 64;
    localparam int unsigned KEY_COUNT    = 70;
    localparam int unsigned KEY_A        = 22;
    localparam int unsigned KEY_Z        = 47;
    localparam int unsigned KEY_ESCAPE   = 48;
    localparam int unsigned KEY_DIGIT0   = 49;
    localparam int unsigned KEY_DIGIT9   = 58;
    localparam int unsigned KEY_PERIOD   = 59;
    localparam int unsigned KEY_COMMA    = 60;
    localparam int unsigned KEY_RETURN   = 61;
    localparam int unsigned KEY_BKSP     = 62;

    // Longest byte sequence one press can produce.
    localparam int unsigned SEQ_DEPTH = 7;

    localparam logic [3:0] ACTION_NONE = 4'd0;

    // Characters.
    localparam logic [7:0] CHR_ESC    = 8'h1B;
    localparam logic [7:0] CHR_CSI    = 8'h5B;
    localparam logic [7:0] CHR_SS3    = 8'h4F;
    localparam logic [7:0] CHR_SEMI   = 8'h3B;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_NINE   = 8'h39;
    localparam logic [7:0] CHR_LOWER_A = 8'h61;
    localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHR_BACKTAB = 8'h5A;
    localparam logic [7:0] CHR_PERIOD = 8'h2E;
    localparam logic [7:0] CHR_COMMA  = 8'h2C;
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_DEL    = 8'h7F;
    localparam logic [7:0] CHR_TAB    = 8'h09;
    localparam logic [7:0] CHR_BS     = 8'h08;
    localparam logic [7:0] CASE_BIT   = 8'h20;
    localparam logic [7:0] CTRL_MASK  = 8'h1F;
    localparam logic [7:0] META_BIT   = 8'h80;
    localparam logic [7:0] UTF8_LEAD  = 8'hC0;
    localparam logic [7:0] UTF8_CONT  = 8'h80;
    localparam logic [7:0] FIN_P      = 8'h50;
    localparam logic [7:0] FIN_S      = 8'h53;
    localparam logic [7:0] FIN_A      = 8'h41;
    localparam logic [7:0] FIN_B      = 8'h42;

    // Numeric parameter and final byte of each function, cursor and editing key.
    localparam logic [4:0] NAV_NUM [NAV_KEYS] = '{
        5'd1,  5'd1,  5'd1,  5'd1,  5'd15, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd23,
        5'd24, 5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd2,  5'd3,  5'd5,  5'd6
    };
    localparam logic [7:0] NAV_FIN [NAV_KEYS] = '{
        8'h50, 8'h51, 8'h52, 8'h53, 8'h7E, 8'h7E, 8'h7E, 8'h7E, 8'h7E, 8'h7E, 8'h7E,
        8'h7E, 8'h41, 8'h42, 8'h43, 8'h44, 8'h48, 8'h46, 8'h7E, 8'h7E, 8'h7E, 8'h7E
    };

    // Control codes for ctrl held with a digit key.
    localparam logic [7:0] CTRL_DIGIT [10] = '{
        8'h30, 8'h31, 8'h00, 8'h1B, 8'h1C, 8'h1D, 8'h1E, 8'h1F, 8'h7F, 8'h39
    };

endpackage

`default_nettype wire

[src/terminal_key_escape_encoder.sv]
`default_nettype none

// Terminal key escape encoder. Key events arrive one per beat on the s_ channel;
// modifier presses and releases update the held-modifier set, and a press of a
// mapped key produces its terminal byte sequence on the m_ channel, one byte per
// beat, with last_of_run marking the final beat of the event. An unmodified F1 to
// F8 gives a single beat with byte_valid low and local_action set instead. Each
// event is held in the input register and is then encoded in a single pass into
// a sequence buffer; an event with no output leaves as it is encoded, and one
// with results holds the output until its last beat is taken (at most seven bytes),
// while the next event waits in the input register. The rate is therefore one
// event per cycle when there is no output; otherwise the next event is encoded as the last beat is taken.
module terminal_key_escape_encoder (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire tkee_pkg::tkee_in_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output tkee_pkg::tkee_out_t       m_data
);
    import tkee_pkg::*;

    // Input register.
    logic       in_valid_reg, in_valid_next;
    tkee_in_t   in_item_reg;

    // Held modifiers: bit i set while key 64+i is down.
    logic [5:0] held_mod_reg, held_mod_next;

    // Sequence buffer being delivered.
    logic       seq_valid_reg, seq_valid_next;
    logic [7:0] seq_buf_reg [SEQ_DEPTH];
    logic [2:0] seq_len_reg;
    logic [2:0] seq_idx_reg, seq_idx_next;
    logic [3:0] seq_action_reg;

    // Encoder results.
    logic [7:0] enc_buf [SEQ_DEPTH];
    logic [2:0] enc_len;
    logic [3:0] enc_action;

    // Encoder working signals.
    logic [6:0] key;
    logic       shift, alt, ctrl, any_mod;
    logic [3:0] delta;
    logic [4:0] nav_num;
    logic [7:0] nav_fin;
    logic [7:0] base;
    logic [7:0] cval;
    logic       is_alpha, is_digit;
    logic [2:0] n;

    logic seq_last, seq_done, load;

    // Handshake and transfer control.
    assign seq_last = (seq_idx_reg == (seq_len_reg - 3'd1));
    assign seq_done = seq_valid_reg && m_ready && seq_last;
    assign load     = in_valid_reg && (!seq_valid_reg || seq_done);
    assign s_ready  = !in_valid_reg || load;

    // Output beat comes straight from the sequence registers.
    assign m_valid              = seq_valid_reg;
    assign m_data.out_byte      = seq_buf_reg[seq_idx_reg];
    assign m_data.byte_valid    = (seq_action_reg == ACTION_NONE);
    assign m_data.local_action  = seq_action_reg;
    assign m_data.last_of_run   = seq_last;

    // Modifier classes and the xterm modifier parameter.
    assign key     = in_item_reg.key_index;
    assign shift   = |held_mod_reg[1:0];
    assign alt     = |held_mod_reg[3:2];
    assign ctrl    = |held_mod_reg[5:4];
    assign any_mod = shift || alt || ctrl;
    assign delta   = {1'b0, ctrl, alt, shift} + 4'd1;

    // Encode the event held in the input register.
    always_comb begin
        for (int i = 0; i < SEQ_DEPTH; i++) begin
            enc_buf[i] = '0;
        end
        n          = '0;
        enc_action = ACTION_NONE;
        nav_num    = '0;
        nav_fin    = '0;
        base       = '0;
        cval       = '0;
        is_alpha   = 1'b0;
        is_digit   = 1'b0;

        if (!in_item_reg.pressed || key >= 7'(KEY_MOD_BASE)) begin
            n = '0;
        end else if (key < 7'(NAV_KEYS)) begin
            nav_num = NAV_NUM[key[4:0]];
            nav_fin = NAV_FIN[key[4:0]];
            if (!any_mod && key < 7'(ACTION_KEYS)) begin
                // Unmodified F1 to F8 report a local action.
                enc_action = 4'(key[2:0]) + 4'd1;
                n          = 3'd1;
            end else begin
                enc_buf[n] = CHR_ESC;
                n = n + 3'd1;
                if ((nav_fin >= FIN_P && nav_fin <= FIN_S) ||
                    (nav_fin >= FIN_A && nav_fin <= FIN_B && !any_mod)) begin
                    enc_buf[n] = CHR_SS3;
                end else begin
                    enc_buf[n] = CHR_CSI;
                end
                n = n + 3'd1;
                if (any_mod || nav_num != 5'd1) begin
                    if (nav_num >= 5'd20) begin
                        enc_buf[n] = CHR_ZERO + 8'd2;
                        n = n + 3'd1;
                        enc_buf[n] = CHR_ZERO + {3'b0, nav_num - 5'd20};
                    end else if (nav_num >= 5'd10) begin
                        enc_buf[n] = CHR_ZERO + 8'd1;
                        n = n + 3'd1;
                        enc_buf[n] = CHR_ZERO + {3'b0, nav_num - 5'd10};
                    end else begin
                        enc_buf[n] = CHR_ZERO + {3'b0, nav_num};
                    end
                    n = n + 3'd1;
                end
                if (any_mod) begin
                    enc_buf[n] = CHR_SEMI;
                    n = n + 3'd1;
                    enc_buf[n] = CHR_ZERO + {4'b0, delta};
                    n = n + 3'd1;
                end
                enc_buf[n] = nav_fin;
                n = n + 3'd1;
            end
        end else begin
            // Base character of a character key.
            if (key >= 7'(KEY_A) && key <= 7'(KEY_Z)) begin
                base = CHR_LOWER_A + ({1'b0, key} - 8'(KEY_A));
            end else if (key == 7'(KEY_ESCAPE)) begin
                base = CHR_ESC;
            end else if (key >= 7'(KEY_DIGIT0) && key <= 7'(KEY_DIGIT9)) begin
                base = CHR_ZERO + ({1'b0, key} - 8'(KEY_DIGIT0));
            end else if (key == 7'(KEY_PERIOD)) begin
                base = CHR_PERIOD;
            end else if (key == 7'(KEY_COMMA)) begin
                base = CHR_COMMA;
            end else if (key == 7'(KEY_RETURN)) begin
                base = CHR_CR;
            end else if (key == 7'(KEY_BKSP)) begin
                base = CHR_DEL;
            end else begin
                base = CHR_TAB;
            end
            is_digit = (base >= CHR_ZERO) && (base <= CHR_NINE);
            is_alpha = (base >= CHR_LOWER_A) && (base <= CHR_LOWER_Z);

            // Shift, ctrl and alt transforms.
            cval = base;
            if (shift && is_alpha) begin
                cval = cval & ~CASE_BIT;
            end
            if (ctrl && is_digit) begin
                cval = CTRL_DIGIT[4'(base[3:0])];
            end
            if (ctrl && base == CHR_DEL) begin
                cval = CHR_BS;
            end else if (ctrl && !is_digit) begin
                cval = cval & CTRL_MASK;
            end
            if (alt) begin
                cval = cval | META_BIT;
            end

            // Plain and shifted text keys are left to text input.
            if ((!is_alpha && !is_digit) || ctrl || alt) begin
                if (shift && cval == CHR_TAB) begin
                    enc_buf[0] = CHR_ESC;
                    enc_buf[1] = CHR_CSI;
                    enc_buf[2] = CHR_BACKTAB;
                    n = 3'd3;
                end else if (!cval[7]) begin
                    enc_buf[0] = cval;
                    n = 3'd1;
                end else begin
                    enc_buf[0] = UTF8_LEAD | {6'b0, cval[7:6]};
                    enc_buf[1] = UTF8_CONT | {2'b0, cval[5:0]};
                    n = 3'd2;
                end
            end
        end
        enc_len = n;
    end

    // Next-state logic.
    always_comb begin
        in_valid_next  = in_valid_reg;
        held_mod_next  = held_mod_reg;
        seq_valid_next = seq_valid_reg;
        seq_idx_next   = seq_idx_reg;

        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (load) begin
            in_valid_next = 1'b0;
        end

        if (load) begin
            if (key >= 7'(KEY_MOD_BASE) && key < 7'(KEY_COUNT)) begin
                held_mod_next[key[2:0]] = in_item_reg.pressed;
            end
            seq_valid_next = (enc_len != 3'd0);
            seq_idx_next   = '0;
        end else if (seq_done) begin
            seq_valid_next = 1'b0;
        end else if (seq_valid_reg && m_ready) begin
            seq_idx_next = seq_idx_reg + 3'd1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            held_mod_reg  <= '0;
            seq_valid_reg <= 1'b0;
            seq_idx_reg   <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            held_mod_reg  <= held_mod_next;
            seq_valid_reg <= seq_valid_next;
            seq_idx_reg   <= seq_idx_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (load) begin
            seq_buf_reg    <= enc_buf;
            seq_len_reg    <= enc_len;
            seq_action_reg <= enc_action;
        end
    end

`ifndef SYNTH
    // The delivery index stays inside the loaded sequence.
    assert property (@(posedge aclk) disable iff (!aresetn)
        seq_valid_reg |-> (seq_idx_reg < seq_len_reg))
        else $error("sequence index beyond sequence length");

    // A local action is always a run of exactly one beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_valid_reg && seq_action_reg != ACTION_NONE) |-> (seq_len_reg == 3'd1))
        else $error("local action run longer than one beat");

    // A stalled result beat keeps its place in the sequence.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && seq_valid_reg && !m_ready) |=> (seq_valid_reg && $stable(seq_idx_reg)))
        else $error("sequence advanced while output stalled");

    // Modifier state changes only when an event leaves the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && !load) |=> $stable(held_mod_reg))
        else $error("modifier state changed without an event");

    // A new event is never encoded while a run is still mid-delivery.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (load && seq_valid_reg) |-> seq_done)
        else $error("sequence overwritten before its last beat");
`endif

endmodule

`default_nettype wire
